FILE: rtl/smbmst_pkg.sv
// Shared types and constants for the SMBus master transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none

package smbmst_pkg;

  localparam int BUFFER_DEPTH_DEF = 16;

  // Top nibble of the bus status register
  localparam logic [3:0] ST_START_SENT = 4'hE;
  localparam logic [3:0] ST_BYTE_SENT  = 4'hC;
  localparam logic [3:0] ST_BYTE_RECV  = 4'h8;

  localparam logic [7:0] ADDR_MASK = 8'hFE;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_EVENT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    action_t    action;
    logic [3:0] byte_index;
    logic [7:0] data_byte;
    logic [7:0] dev_address;
    logic [4:0] length;
    logic [3:0] status_code;
    logic       ack_in;
    logic       arb_lost;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       start_req;
    logic       stop_req;
    logic       ack_out;
    logic       bus_reset;
    logic       busy_res;
    logic       outcome;
    logic [7:0] rx_data;
    logic       rejected;
  } res_t;

  // Write buffer command from the sequencer
  typedef struct packed {
    logic       we;
    logic       clr;
    logic [7:0] wdata;
  } buf_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/smbmst_buf.sv
// Write buffer: byte memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module smbmst_buf import smbmst_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire buf_cmd_t                               cmd,
  input  wire logic [((BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1)-1:0] waddr,
  input  wire logic [$clog2(BUFFER_DEPTH + 1)-1:0]    clr_end,
  input  wire logic                                   rd_en,
  input  wire logic [$clog2(BUFFER_DEPTH + 1)-1:0]    raddr,
  input  wire logic [$clog2(BUFFER_DEPTH + 1)-1:0]    cur_pos,
  output logic [7:0]                                  rd_byte
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int POS_W = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]              mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] valid;
  logic [7:0]              rdata;
  logic [IDX_W-1:0]        ridx;
  logic [IDX_W-1:0]        cidx;
  logic                    cur_ok;

  assign ridx   = IDX_W'(raddr);
  assign cidx   = IDX_W'(cur_pos);
  assign cur_ok = cur_pos < POS_W'(BUFFER_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= cmd.wdata;
    end
    // read-during-write returns the new byte
    if (rd_en) begin
      if (cmd.we && waddr == ridx) begin
        rdata <= cmd.wdata;
      end else begin
        rdata <= mem[ridx];
      end
    end
  end

  // entries never written since reset, or since a clear that covered them (below clr_end), read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.clr) begin
        for (int k = 0; k < BUFFER_DEPTH; k++) begin
          if (POS_W'(k) < clr_end) begin
            valid[k] <= 1'b0;
          end
        end
      end
      if (cmd.we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rd_byte = (cur_ok && valid[cidx]) ? rdata : 8'h00;

endmodule

`default_nettype wire

FILE: rtl/smbmst_seq.sv
// Transfer sequencer: state registers and the per-item decision logic.
`timescale 1ns / 1ps
`default_nettype none

module smbmst_seq import smbmst_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   fire,
  input  wire item_t                                  item,
  input  wire logic [7:0]                             buf_byte,
  output res_t                                        res,
  output buf_cmd_t                                    cmd,
  output logic [((BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1)-1:0] waddr,
  output logic [$clog2(BUFFER_DEPTH + 1)-1:0]         clr_end,
  output logic [$clog2(BUFFER_DEPTH + 1)-1:0]         raddr,
  output logic [$clog2(BUFFER_DEPTH + 1)-1:0]         cur_pos
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int POS_W = $clog2(BUFFER_DEPTH + 1);
  localparam int LW    = (POS_W > 5) ? POS_W : 5;
  localparam int LI    = (POS_W > 4) ? POS_W : 4;

  phase_t           phase, phase_next;
  logic             is_read, is_read_next;
  logic             busy, busy_next;
  logic             success, success_next;
  logic [7:0]       target_address, target_address_next;
  logic [POS_W-1:0] send_position, send_position_next;
  logic [POS_W-1:0] send_end, send_end_next;
  logic [7:0]       read_byte, read_byte_next;

  logic [LW-1:0]    len_w;
  logic [POS_W-1:0] len_sat;
  logic             idx_ok;
  logic             fail;

  assign len_w   = LW'(item.length);
  assign len_sat = (len_w > LW'(BUFFER_DEPTH)) ? POS_W'(BUFFER_DEPTH) : POS_W'(len_w);
  assign idx_ok  = LI'(item.byte_index) < LI'(BUFFER_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      is_read        <= 1'b0;
      busy           <= 1'b0;
      success        <= 1'b0;
      target_address <= '0;
      send_position  <= '0;
      send_end       <= '0;
      read_byte      <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      is_read        <= is_read_next;
      busy           <= busy_next;
      success        <= success_next;
      target_address <= target_address_next;
      send_position  <= send_position_next;
      send_end       <= send_end_next;
      read_byte      <= read_byte_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    is_read_next        = is_read;
    busy_next           = busy;
    success_next        = success;
    target_address_next = target_address;
    send_position_next  = send_position;
    send_end_next       = send_end;
    read_byte_next      = read_byte;
    res                 = '0;
    cmd                 = '0;
    cmd.wdata           = item.data_byte;
    fail                = 1'b0;

    unique case (item.action) inside
      ACT_LOAD: begin
        cmd.we = idx_ok;
      end
      ACT_WRITE, ACT_READ: begin
        if (busy) begin
          res.rejected = 1'b1;
        end else begin
          success_next        = 1'b0;
          target_address_next = item.dev_address;
          is_read_next        = (item.action == ACT_READ);
          if (item.action == ACT_WRITE) begin
            send_end_next      = len_sat;
            send_position_next = '0;
          end
          phase_next    = PH_IDLE;
          busy_next     = 1'b1;
          res.start_req = 1'b1;
        end
      end
      default: begin
        if (busy) begin
          if (item.arb_lost) begin
            fail = 1'b1;
          end else begin
            case (item.status_code)
              ST_START_SENT: begin
                res.tx_valid = 1'b1;
                res.tx_byte  = (target_address & ADDR_MASK) | {7'd0, is_read};
                phase_next   = (!is_read && send_end == '0) ? PH_DONE : PH_DATA;
              end
              ST_BYTE_SENT: begin
                if (item.ack_in && phase == PH_DATA) begin
                  if (!is_read) begin
                    if (send_position < send_end &&
                        send_position < POS_W'(BUFFER_DEPTH)) begin
                      res.tx_valid = 1'b1;
                      res.tx_byte  = buf_byte;
                    end
                    // once past the end the position only has to stay past it
                    if (send_position >= send_end) begin
                      phase_next = PH_DONE;
                    end else begin
                      send_position_next = send_position + 1'b1;
                      if (send_position + 1'b1 >= send_end) begin
                        phase_next = PH_DONE;
                      end
                    end
                  end
                end else if (item.ack_in && phase == PH_DONE) begin
                  res.stop_req       = 1'b1;
                  cmd.clr            = 1'b1;
                  send_end_next      = '0;
                  send_position_next = '0;
                  busy_next          = 1'b0;
                  success_next       = 1'b1;
                  phase_next         = PH_IDLE;
                end else begin
                  res.stop_req = 1'b1;
                  busy_next    = 1'b0;
                  success_next = 1'b0;
                  phase_next   = PH_IDLE;
                end
              end
              ST_BYTE_RECV: begin
                read_byte_next = item.rx_byte;
                res.stop_req   = 1'b1;
                busy_next      = 1'b0;
                success_next   = 1'b1;
                phase_next     = PH_IDLE;
              end
              default: begin
                fail = 1'b1;
              end
            endcase
          end
          if (fail) begin
            res.bus_reset = 1'b1;
            res.tx_valid  = 1'b0;
            res.tx_byte   = 8'h00;
            res.stop_req  = 1'b0;
            busy_next     = 1'b0;
            success_next  = 1'b0;
            phase_next    = PH_IDLE;
          end
        end
      end
    endcase

    res.ack_out  = 1'b0;
    res.busy_res = busy_next;
    res.outcome  = success_next;
    res.rx_data  = read_byte_next;
  end

  assign waddr   = IDX_W'(item.byte_index);
  assign clr_end = send_end;
  assign cur_pos = send_position;
  // position the next item will see
  assign raddr   = fire ? send_position_next : send_position;

endmodule

`default_nettype wire

FILE: rtl/smbus_master_transfer_sequencer.sv
// Top level of the SMBus master transfer sequencer: item and result registers.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall): one item per handshake carrying
//   an action (load buffer byte, start write, start read, bus event) and the
//   fields that action needs. Result channel (res_valid / res_stall): exactly
//   one result item per command item, in order.
//   Each command item is first captured in an input register; the sequencer
//   logic then decides on it and the result lands in an output register.
//   Throughput is one item per cycle while the result side does not stall,
//   set by the single decision stage between the two registers. The write
//   buffer read is issued while an item is captured so its byte is ready
//   when that item is decided.
//   When the result side stalls, the held result stays put and the input
//   register still takes one more item; cmd_stall rises only when both are
//   full and the result is not taken.
//   Reset (rst, synchronous) empties both registers, returns the sequencer
//   to idle with outcome 0, and marks every buffer byte as zero. No clearing
//   pass is needed; the block takes items right after reset.
`timescale 1ns / 1ps
`default_nettype none

module smbus_master_transfer_sequencer import smbmst_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // command channel
  input  wire logic       cmd_valid,
  output logic            cmd_stall,
  input  wire logic [1:0] action,
  input  wire logic [3:0] byte_index,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] dev_address,
  input  wire logic [4:0] length,
  input  wire logic [3:0] status_code,
  input  wire logic       ack_in,
  input  wire logic       arb_lost,
  input  wire logic [7:0] rx_byte,
  // result channel
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            start_req,
  output logic            stop_req,
  output logic            ack_out,
  output logic            bus_reset,
  output logic            busy_res,
  output logic            outcome,
  output logic [7:0]      rx_data,
  output logic            rejected
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int POS_W = $clog2(BUFFER_DEPTH + 1);

  item_t            item_q;
  logic             item_vld;
  res_t             res_q;
  res_t             res_d;
  logic             fire;
  logic             load;

  buf_cmd_t         cmd;
  buf_cmd_t         buf_cmd;
  logic [IDX_W-1:0] waddr;
  logic [POS_W-1:0] clr_end;
  logic [POS_W-1:0] raddr;
  logic [POS_W-1:0] cur_pos;
  logic [7:0]       buf_byte;

  // decide the held item when the result register is free or being drained
  assign fire      = item_vld && (!res_valid || !res_stall);
  assign cmd_stall = item_vld && !fire;
  assign load      = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (load) begin
      item_vld <= 1'b1;
    end else if (fire) begin
      item_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q.action        <= action_t'(action);
      item_q.byte_index    <= byte_index;
      item_q.data_byte     <= data_byte;
      item_q.dev_address   <= dev_address;
      item_q.length        <= length;
      item_q.status_code   <= status_code;
      item_q.ack_in        <= ack_in;
      item_q.arb_lost      <= arb_lost;
      item_q.rx_byte       <= rx_byte;
    end
  end

  smbmst_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (item_q),
    .buf_byte (buf_byte),
    .res      (res_d),
    .cmd      (cmd),
    .waddr    (waddr),
    .clr_end  (clr_end),
    .raddr    (raddr),
    .cur_pos  (cur_pos)
  );

  // buffer only changes when the item is actually decided
  assign buf_cmd.we    = cmd.we && fire;
  assign buf_cmd.clr   = cmd.clr && fire;
  assign buf_cmd.wdata = cmd.wdata;

  smbmst_buf #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_buf (
    .clk     (clk),
    .rst     (rst),
    .cmd     (buf_cmd),
    .waddr   (waddr),
    .clr_end (clr_end),
    .rd_en   (load),
    .raddr   (raddr),
    .cur_pos (cur_pos),
    .rd_byte (buf_byte)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign tx_valid  = res_q.tx_valid;
  assign tx_byte   = res_q.tx_byte;
  assign start_req = res_q.start_req;
  assign stop_req  = res_q.stop_req;
  assign ack_out   = res_q.ack_out;
  assign bus_reset = res_q.bus_reset;
  assign busy_res  = res_q.busy_res;
  assign outcome   = res_q.outcome;
  assign rx_data   = res_q.rx_data;
  assign rejected  = res_q.rejected;

`ifndef SYNTHESIS
  // a rejected start leaves the running transfer in place
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && rejected |-> busy_res)
    else $error("rejected start without busy transfer");

  // a stop or a bus reset always ends the transfer
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && (stop_req || bus_reset) |-> !busy_res)
    else $error("transfer still busy after stop or bus reset");

  a_reset_fail: assert property (@(posedge clk) disable iff (rst)
    res_valid && bus_reset |-> !outcome && !tx_valid && !stop_req)
    else $error("bus reset with success or bus activity");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && start_req |-> busy_res && !outcome && !rejected)
    else $error("start request without fresh busy state");

  // an item that is not decided stays in the input register
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_vld && !fire |=> item_vld && $stable(item_q))
    else $error("held item lost or changed");
`endif

endmodule

`default_nettype wire
